// ===== rtl/core/ipv4hc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4hc_pkg
// Shared types, register indexes and defaults of the IPv4 input header check.
// ----------------------------------------------------------------------------
package ipv4hc_pkg;

   // parameter defaults
   localparam int BAD_SOURCE_SLOTS_DEF  = 3;
   localparam int GOOD_DEST_SLOTS_DEF   = 2;
   localparam int LINK_HEADER_BYTES_DEF = 14;

   // protocol constants
   localparam int MIN_IP_HEADER = 20;
   localparam int IP_VERSION    = 4;

   // number of list slots that have a register index of their own
   localparam int BAD_REG_SLOTS  = 3;
   localparam int GOOD_REG_SLOTS = 2;

   // register interface
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PAINT      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAD_COUNT  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAD_0      = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOOD_COUNT = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOOD_0     = 4'd6;

   // drop reasons, first failing check wins
   typedef enum logic [2:0] {
      REASON_OK        = 3'd0,
      REASON_SHORT     = 3'd1,
      REASON_VERSION   = 3'd2,
      REASON_HDR_LEN   = 3'd3,
      REASON_TOTAL_LEN = 3'd4,
      REASON_CHECKSUM  = 3'd5,
      REASON_BAD_SRC   = 3'd6
   } reason_type;

   // header view of the frame as of its last byte
   typedef struct packed {
      logic [7:0]  version_ihl;
      logic [15:0] total_len;
      logic [15:0] csum;
      logic [16:0] ip_len;
      logic [31:0] src;
      logic [31:0] dst;
   } hdr_type;

   typedef struct packed {
      reason_type  reason;
      logic [5:0]  hdr_bytes;
   } verdict_type;

endpackage

// ===== rtl/core/ipv4hc_if.sv =====
// ----------------------------------------------------------------------------
// ipv4hc_if
// Valid/ready channels of the IPv4 input header check: frame bytes in,
// verdicts out, register writes.
// ----------------------------------------------------------------------------
interface ipv4hc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface ipv4hc_rsp_if;
   logic        valid;
   logic        ready;
   logic        accept;
   logic [2:0]  drop_reason;
   logic [5:0]  header_bytes;
   logic [15:0] kept_length;
   logic [31:0] dst_address;
   logic [7:0]  color_out;
   logic [31:0] drop_count;

   modport source (output valid, output accept, output drop_reason, output header_bytes,
                   output kept_length, output dst_address, output color_out,
                   output drop_count, input ready);
   modport sink   (input valid, input accept, input drop_reason, input header_bytes,
                   input kept_length, input dst_address, input color_out,
                   input drop_count, output ready);
endinterface

interface ipv4hc_csr_if;
   import ipv4hc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ipv4_input_header_check_unit.sv =====
// ----------------------------------------------------------------------------
// ipv4_input_header_check_unit
// Watches an Ethernet frame byte by byte, checks the IPv4 header behind the
// link header and gives one verdict per frame on its last byte.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  req_bus   in         frame_byte, frame_end (one frame byte per transfer)
//  rsp_bus   out        verdict fields, one transfer per frame
//  csr_bus   in         register index and write data
//
//  one byte per cycle sustained while no last byte waits on a full result
//  register; a frame's verdict is loaded into the result register as its last
//  byte leaves the input register.
//  reset clears the configuration, the frame state and the drop count.
//  only a last byte waits on a full result register; other bytes keep flowing.
//  register writes are taken every cycle.
// ----------------------------------------------------------------------------
module ipv4_input_header_check_unit #(
   parameter int BAD_SOURCE_SLOTS  = ipv4hc_pkg::BAD_SOURCE_SLOTS_DEF,
   parameter int GOOD_DEST_SLOTS   = ipv4hc_pkg::GOOD_DEST_SLOTS_DEF,
   parameter int LINK_HEADER_BYTES = ipv4hc_pkg::LINK_HEADER_BYTES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   ipv4hc_req_if.sink     req_bus,
   ipv4hc_rsp_if.source   rsp_bus,
   ipv4hc_csr_if.sink     csr_bus
);
   import ipv4hc_pkg::*;

   localparam logic [15:0] LINK_LEN = 16'(LINK_HEADER_BYTES);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       advance;
   logic       req_ready;

   // configuration
   logic [7:0]  paint_ff;
   logic [1:0]  bad_count_ff;
   logic [1:0]  good_count_ff;
   logic [31:0] bad_src_ff [BAD_SOURCE_SLOTS];
   logic [31:0] good_dst_ff [GOOD_DEST_SLOTS];

   // frame state
   logic [15:0] byte_index_ff, byte_index_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [15:0] csum_ff, csum_in;
   logic [7:0]  pend_ff, pend_in;
   logic [31:0] tally_ff, tally_in;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_accept_ff;
   reason_type  rsp_reason_ff;
   logic [5:0]  rsp_hdr_ff;
   logic [15:0] rsp_len_ff;
   logic [31:0] rsp_dst_ff;
   logic [7:0]  rsp_color_ff;
   logic [31:0] rsp_count_ff;

   logic [15:0] offset;
   logic        in_ip;
   logic [5:0]  hl_in;
   logic [16:0] csum_sum;
   logic [16:0] byte_count;
   logic [16:0] ip_len;
   hdr_type     hdr;
   verdict_type verdict;
   logic        is_drop;

   // handshakes
   assign advance   = in_valid_ff && (!in_end_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_bus.valid) begin
         in_byte_ff <= req_bus.frame_byte;
         in_end_ff  <= req_bus.frame_end;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         paint_ff      <= '0;
         bad_count_ff  <= '0;
         good_count_ff <= '0;
         for (int s = 0; s < BAD_SOURCE_SLOTS; s++) bad_src_ff[s] <= '0;
         for (int s = 0; s < GOOD_DEST_SLOTS; s++) good_dst_ff[s] <= '0;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == CSR_PAINT) paint_ff <= csr_bus.data[7:0];
         if (csr_bus.index == CSR_BAD_COUNT) bad_count_ff <= csr_bus.data[1:0];
         if (csr_bus.index == CSR_GOOD_COUNT) good_count_ff <= csr_bus.data[1:0];
         for (int s = 0; s < BAD_SOURCE_SLOTS; s++) begin
            if ((s < BAD_REG_SLOTS) &&
                (csr_bus.index == CSR_INDEX_W'(int'(CSR_BAD_0) + s)))
               bad_src_ff[s] <= csr_bus.data;
         end
         for (int s = 0; s < GOOD_DEST_SLOTS; s++) begin
            if ((s < GOOD_REG_SLOTS) &&
                (csr_bus.index == CSR_INDEX_W'(int'(CSR_GOOD_0) + s)))
               good_dst_ff[s] <= csr_bus.data;
         end
      end
   end

   // header capture and running checksum for the byte in the input register
   assign in_ip  = byte_index_ff >= LINK_LEN;
   assign offset = byte_index_ff - LINK_LEN;

   always_comb begin
      vihl_in = vihl_ff;
      tlen_in = tlen_ff;
      src_in  = src_ff;
      dst_in  = dst_ff;
      if (in_ip) begin
         if (offset == 16'd0) vihl_in = in_byte_ff;
         else if (offset == 16'd2) tlen_in = {in_byte_ff, tlen_ff[7:0]};
         else if (offset == 16'd3) tlen_in = {tlen_ff[15:8], in_byte_ff};
         else if (offset >= 16'd12 && offset < 16'd16) src_in = {src_ff[23:0], in_byte_ff};
         else if (offset >= 16'd16 && offset < 16'd20) dst_in = {dst_ff[23:0], in_byte_ff};
      end
   end

   assign hl_in    = {vihl_in[3:0], 2'b00};
   assign csum_sum = {1'b0, csum_ff} + {1'b0, pend_ff, in_byte_ff};

   always_comb begin
      pend_in = pend_ff;
      csum_in = csum_ff;
      if (in_ip && (offset < {10'b0, hl_in})) begin
         if (!offset[0]) begin
            pend_in = in_byte_ff;
         end else if (csum_sum[16]) begin
            csum_in = csum_sum[15:0] + 16'd1;
         end else begin
            csum_in = csum_sum[15:0];
         end
      end
   end

   assign byte_index_in = (byte_index_ff != 16'hFFFF) ? byte_index_ff + 16'd1 : byte_index_ff;

   // bytes present behind the link header, this byte included
   assign byte_count = {1'b0, byte_index_ff} + 17'd1;
   assign ip_len     = (byte_count > {1'b0, LINK_LEN}) ? byte_count - {1'b0, LINK_LEN} : 17'd0;

   assign hdr.version_ihl = vihl_in;
   assign hdr.total_len   = tlen_in;
   assign hdr.csum        = csum_in;
   assign hdr.ip_len      = ip_len;
   assign hdr.src         = src_in;
   assign hdr.dst         = dst_in;

   ipv4hc_verdict #(
      .BAD_SOURCE_SLOTS (BAD_SOURCE_SLOTS),
      .GOOD_DEST_SLOTS  (GOOD_DEST_SLOTS)
   ) u_verdict (
      .hdr        (hdr),
      .bad_count  (bad_count_ff),
      .bad_src    (bad_src_ff),
      .good_count (good_count_ff),
      .good_dst   (good_dst_ff),
      .verdict    (verdict)
   );

   assign is_drop  = verdict.reason != REASON_OK;
   assign tally_in = (is_drop && tally_ff != 32'hFFFF_FFFF) ? tally_ff + 32'd1 : tally_ff;

   // frame state update, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         vihl_ff       <= '0;
         tlen_ff       <= '0;
         src_ff        <= '0;
         dst_ff        <= '0;
         csum_ff       <= '0;
         pend_ff       <= '0;
         tally_ff      <= '0;
      end else if (advance) begin
         if (in_end_ff) begin
            byte_index_ff <= '0;
            vihl_ff       <= '0;
            tlen_ff       <= '0;
            src_ff        <= '0;
            dst_ff        <= '0;
            csum_ff       <= '0;
            pend_ff       <= '0;
            tally_ff      <= tally_in;
         end else begin
            byte_index_ff <= byte_index_in;
            vihl_ff       <= vihl_in;
            tlen_ff       <= tlen_in;
            src_ff        <= src_in;
            dst_ff        <= dst_in;
            csum_ff       <= csum_in;
            pend_ff       <= pend_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_end_ff) begin
         rsp_accept_ff <= !is_drop;
         rsp_reason_ff <= verdict.reason;
         rsp_hdr_ff    <= is_drop ? 6'd0 : verdict.hdr_bytes;
         rsp_len_ff    <= is_drop ? 16'd0 : tlen_in;
         rsp_dst_ff    <= is_drop ? 32'd0 : dst_in;
         rsp_color_ff  <= paint_ff;
         rsp_count_ff  <= tally_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.accept       = rsp_accept_ff;
   assign rsp_bus.drop_reason  = rsp_reason_ff;
   assign rsp_bus.header_bytes = rsp_hdr_ff;
   assign rsp_bus.kept_length  = rsp_len_ff;
   assign rsp_bus.dst_address  = rsp_dst_ff;
   assign rsp_bus.color_out    = rsp_color_ff;
   assign rsp_bus.drop_count   = rsp_count_ff;

   // checks
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      advance && !in_end_ff && byte_index_ff != 16'hFFFF
      |=> byte_index_ff == $past(byte_index_ff) + 16'd1)
      else $error("byte index did not step on a middle byte");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_end_ff |=> byte_index_ff == 16'd0 && csum_ff == 16'd0 && vihl_ff == 8'd0)
      else $error("frame state not cleared after last byte");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_end_ff |=> rsp_valid_ff)
      else $error("last byte produced no result");

   a_accept_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_accept_ff
      |-> rsp_reason_ff != REASON_OK && rsp_hdr_ff == 6'd0 && rsp_dst_ff == 32'd0)
      else $error("dropped frame carries header fields");

endmodule

// ===== rtl/core/ipv4hc_verdict.sv =====
// ----------------------------------------------------------------------------
// ipv4hc_verdict
// Runs the ordered header checks and the address list lookups on the header
// as it stands after the last frame byte.
// ----------------------------------------------------------------------------
module ipv4hc_verdict #(
   parameter int BAD_SOURCE_SLOTS = ipv4hc_pkg::BAD_SOURCE_SLOTS_DEF,
   parameter int GOOD_DEST_SLOTS  = ipv4hc_pkg::GOOD_DEST_SLOTS_DEF
) (
   input  ipv4hc_pkg::hdr_type     hdr,
   input  logic [1:0]              bad_count,
   input  logic [31:0]             bad_src [BAD_SOURCE_SLOTS],
   input  logic [1:0]              good_count,
   input  logic [31:0]             good_dst [GOOD_DEST_SLOTS],
   output ipv4hc_pkg::verdict_type verdict
);
   import ipv4hc_pkg::*;

   logic [5:0] hl;
   logic       src_bad;
   logic       dst_good;

   assign hl = {hdr.version_ihl[3:0], 2'b00};

   // list lookups, only slots in use take part
   always_comb begin
      src_bad = 1'b0;
      for (int i = 0; i < BAD_SOURCE_SLOTS; i++) begin
         if ((i < int'(bad_count)) && (bad_src[i] == hdr.src)) src_bad = 1'b1;
      end
   end

   always_comb begin
      dst_good = 1'b0;
      for (int i = 0; i < GOOD_DEST_SLOTS; i++) begin
         if ((i < int'(good_count)) && (good_dst[i] == hdr.dst)) dst_good = 1'b1;
      end
   end

   // ordered checks
   always_comb begin
      verdict.hdr_bytes = hl;
      if (hdr.ip_len < 17'(MIN_IP_HEADER)) begin
         verdict.reason = REASON_SHORT;
      end else if (hdr.version_ihl[7:4] != 4'(IP_VERSION)) begin
         verdict.reason = REASON_VERSION;
      end else if (hl < 6'(MIN_IP_HEADER)) begin
         verdict.reason = REASON_HDR_LEN;
      end else if (({1'b0, hdr.total_len} > hdr.ip_len) ||
                   (hdr.total_len < {10'b0, hl})) begin
         verdict.reason = REASON_TOTAL_LEN;
      end else if (hdr.csum != 16'hFFFF) begin
         verdict.reason = REASON_CHECKSUM;
      end else if (src_bad && !dst_good) begin
         verdict.reason = REASON_BAD_SRC;
      end else begin
         verdict.reason = REASON_OK;
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IPv4 input header check. Ethernet frames are
// built with real IPv4 headers (good ones, broken ones, truncated ones and
// plain noise) and streamed a byte per transfer. A byte-level predictor
// tracks the header fields and the ones-complement sum, and every verdict
// from the unit is compared field by field against it. Register settings
// change between phases, only while no frame is in flight.
// ----------------------------------------------------------------------------
module tb;
   import ipv4hc_pkg::*;

   localparam int LINK_BYTES     = LINK_HEADER_BYTES_DEF;
   localparam int SETTLE         = 4;
   localparam int MAX_GAP        = 40;
   localparam int RANDOM_BYTES   = 1250;
   localparam int RANDOM_FRAMES  = 20;
   localparam int FRAMES_PER_SET = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_TOP = '1;

   typedef enum logic [1:0] {
      TRAFFIC_BYTE,
      TRAFFIC_CSR,
      TRAFFIC_PAUSE
   } traffic_kind_type;

   typedef struct {
      traffic_kind_type       kind;
      logic [7:0]             data_byte;
      logic                   last;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
   } traffic_type;

   typedef enum int {
      PKT_GOOD,
      PKT_VERSION,
      PKT_HDR_LEN,
      PKT_TOTAL_LONG,
      PKT_TOTAL_SHORT,
      PKT_CSUM,
      PKT_BAD_SRC,
      PKT_NOISE
   } packet_kind_type;

   typedef struct {
      logic        accept;
      reason_type  reason;
      logic [5:0]  hdr_bytes;
      logic [15:0] kept_len;
      logic [31:0] dst;
      logic [7:0]  color;
      logic [31:0] drops;
   } verdict_rec_type;

   logic clock;
   logic reset;

   ipv4hc_req_if req_bus ();
   ipv4hc_rsp_if rsp_bus ();
   ipv4hc_csr_if csr_bus ();

   ipv4_input_header_check_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // bytes and register writes waiting to go out
   traffic_type     link_traffic[$];
   // verdicts predicted but not yet seen
   verdict_rec_type expected_verdicts[$];

   int     verdicts_due;
   logic   traffic_done;
   bit     mismatch_seen;
   longint cycle_count;
   longint cycle_limit;

   // stimulus side copy of the address lists, used to aim sources and destinations
   logic [31:0] gen_bad[BAD_SOURCE_SLOTS_DEF];
   logic [31:0] gen_good[GOOD_DEST_SLOTS_DEF];
   longint      n_bytes;
   longint      n_frames;
   longint      n_pauses;

   // predictor copy of the registers
   logic [7:0]  cfg_paint;
   logic [1:0]  cfg_bad_n;
   logic [31:0] cfg_bad[BAD_SOURCE_SLOTS_DEF];
   logic [1:0]  cfg_good_n;
   logic [31:0] cfg_good[GOOD_DEST_SLOTS_DEF];

   // predictor frame state
   logic [15:0] frame_pos;
   logic [7:0]  ver_ihl_seen;
   logic [15:0] tot_len_seen;
   logic [31:0] src_seen;
   logic [31:0] dst_seen;
   logic [16:0] hdr_sum;
   logic [7:0]  hi_byte;
   logic [31:0] drops_so_far;

   // idle shaping
   int byte_gap;
   int quiet_cycles;
   bit req_calm;
   int req_calm_left;
   int stall_left;
   bit rsp_calm;
   int rsp_calm_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(input bit calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, MAX_GAP);
   endfunction

   // address with a bias toward all zeros and all ones
   function automatic logic [31:0] pick_addr();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll == 0) return 32'h0000_0000;
      if (roll == 1) return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   task automatic clear_frame_state();
      frame_pos    = '0;
      ver_ihl_seen = '0;
      tot_len_seen = '0;
      src_seen     = '0;
      dst_seen     = '0;
      hdr_sum      = '0;
      hi_byte      = '0;
   endtask

   // follow one frame byte; on the last byte queue the verdict
   task automatic track_frame_byte(input logic [7:0] b, input logic last);
      logic [15:0]     pos;
      logic [15:0]     ofs;
      logic [5:0]      hl;
      logic [16:0]     s;
      logic [16:0]     count;
      logic [16:0]     iplen;
      logic            src_bad;
      logic            dst_good;
      reason_type      why;
      verdict_rec_type v;
      pos = frame_pos;
      if (pos >= LINK_BYTES) begin
         ofs = 16'(pos - LINK_BYTES);
         if (ofs == 0) ver_ihl_seen = b;
         else if (ofs == 2) tot_len_seen[15:8] = b;
         else if (ofs == 3) tot_len_seen[7:0] = b;
         else if (ofs >= 12 && ofs < 16) src_seen = {src_seen[23:0], b};
         else if (ofs >= 16 && ofs < 20) dst_seen = {dst_seen[23:0], b};
         hl = {ver_ihl_seen[3:0], 2'b00};
         // ones-complement sum over the header words
         if (ofs < hl) begin
            if (!ofs[0]) begin
               hi_byte = b;
            end else begin
               s = hdr_sum + {hi_byte, b};
               if (s > 17'h0FFFF) s = {1'b0, s[15:0]} + 17'd1;
               hdr_sum = s;
            end
         end
      end
      if (frame_pos != 16'hFFFF) frame_pos = frame_pos + 16'd1;
      if (last) begin
         count = {1'b0, pos} + 17'd1;
         iplen = (count > LINK_BYTES) ? 17'(count - LINK_BYTES) : 17'd0;
         hl    = {ver_ihl_seen[3:0], 2'b00};
         src_bad  = 1'b0;
         dst_good = 1'b0;
         for (int i = 0; i < BAD_SOURCE_SLOTS_DEF; i++)
            if (i < cfg_bad_n && cfg_bad[i] == src_seen) src_bad = 1'b1;
         for (int i = 0; i < GOOD_DEST_SLOTS_DEF; i++)
            if (i < cfg_good_n && cfg_good[i] == dst_seen) dst_good = 1'b1;
         // first failing check wins
         if (iplen < MIN_IP_HEADER) why = REASON_SHORT;
         else if (ver_ihl_seen[7:4] != IP_VERSION) why = REASON_VERSION;
         else if (hl < MIN_IP_HEADER) why = REASON_HDR_LEN;
         else if (tot_len_seen > iplen || tot_len_seen < hl) why = REASON_TOTAL_LEN;
         else if (hdr_sum != 17'h0FFFF) why = REASON_CHECKSUM;
         else if (src_bad && !dst_good) why = REASON_BAD_SRC;
         else why = REASON_OK;
         if (why != REASON_OK && drops_so_far != 32'hFFFF_FFFF)
            drops_so_far = drops_so_far + 32'd1;
         v.accept    = (why == REASON_OK);
         v.reason    = why;
         v.hdr_bytes = (why == REASON_OK) ? hl : 6'd0;
         v.kept_len  = (why == REASON_OK) ? tot_len_seen : 16'd0;
         v.dst       = (why == REASON_OK) ? dst_seen : 32'd0;
         v.color     = cfg_paint;
         v.drops     = drops_so_far;
         expected_verdicts.push_back(v);
         clear_frame_state();
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatch_seen = 1'b1;
      end
   endtask

   task automatic push_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      traffic_type t;
      t.kind      = TRAFFIC_CSR;
      t.data_byte = '0;
      t.last      = 1'b0;
      t.index     = idx;
      t.value     = data;
      link_traffic.push_back(t);
      if (idx >= CSR_BAD_0 && idx < CSR_BAD_0 + BAD_REG_SLOTS)
         gen_bad[idx - CSR_BAD_0] = data;
      if (idx >= CSR_GOOD_0 && idx < CSR_GOOD_0 + GOOD_REG_SLOTS)
         gen_good[idx - CSR_GOOD_0] = data;
   endtask

   // hold the sender until every verdict is in
   task automatic push_pause();
      traffic_type t;
      t.kind      = TRAFFIC_PAUSE;
      t.data_byte = '0;
      t.last      = 1'b0;
      t.index     = '0;
      t.value     = '0;
      link_traffic.push_back(t);
      n_pauses++;
   endtask

   // build one Ethernet frame; ihl_req 0 picks one, cut > 0 truncates the frame
   task automatic push_packet(input packet_kind_type kind, input int ihl_req,
                              input int payload, input int cut);
      logic [7:0]  f[$];
      logic [7:0]  ip[$];
      logic [16:0] acc;
      logic [15:0] csum;
      logic [31:0] src;
      logic [31:0] dst;
      logic [3:0]  ver;
      traffic_type t;
      int          ihl;
      int          hl;
      int          body_len;
      int          pad;
      int          tl;
      int          k;
      if (kind == PKT_NOISE) begin
         for (int i = 0; i < payload; i++) f.push_back(8'($urandom_range(0, 255)));
      end else begin
         ihl = (ihl_req != 0) ? ihl_req
               : (($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5);
         if (kind == PKT_HDR_LEN) ihl = $urandom_range(0, 4);
         hl       = ihl * 4;
         body_len = ((hl > MIN_IP_HEADER) ? hl : MIN_IP_HEADER) + payload;
         pad      = $urandom_range(0, 3);
         ver      = 4'(IP_VERSION);
         if (kind == PKT_VERSION) ver = 4'(IP_VERSION ^ $urandom_range(1, 15));
         tl = hl + payload;
         if (kind == PKT_HDR_LEN) tl = $urandom_range(0, 65535);
         if (kind == PKT_TOTAL_LONG) tl = $urandom_range(body_len + pad + 1, 65535);
         if (kind == PKT_TOTAL_SHORT) tl = $urandom_range(0, hl - 1);
         if (tl > 65535) tl = 65535;
         src = pick_addr();
         dst = pick_addr();
         if (kind == PKT_BAD_SRC) begin
            src = gen_bad[$urandom_range(0, BAD_SOURCE_SLOTS_DEF - 1)];
            if ($urandom_range(0, 1) == 0)
               dst = gen_good[$urandom_range(0, GOOD_DEST_SLOTS_DEF - 1)];
         end
         for (int i = 0; i < LINK_BYTES; i++) f.push_back(8'($urandom_range(0, 255)));
         for (int i = 0; i < body_len; i++) ip.push_back(8'($urandom_range(0, 255)));
         ip[0]  = {ver, ihl[3:0]};
         ip[2]  = tl[15:8];
         ip[3]  = tl[7:0];
         ip[10] = 8'h00;
         ip[11] = 8'h00;
         for (int i = 0; i < 4; i++) begin
            ip[12 + i] = src[31 - 8*i -: 8];
            ip[16 + i] = dst[31 - 8*i -: 8];
         end
         // header checksum
         acc = '0;
         for (int i = 0; i < hl; i += 2) begin
            acc = acc + {ip[i], ip[i + 1]};
            if (acc > 17'h0FFFF) acc = {1'b0, acc[15:0]} + 17'd1;
         end
         csum   = ~acc[15:0];
         ip[10] = csum[15:8];
         ip[11] = csum[7:0];
         if (kind == PKT_CSUM) begin
            k     = $urandom_range(4, hl - 1);
            ip[k] = ip[k] ^ (8'h01 << $urandom_range(0, 7));
         end
         foreach (ip[i]) f.push_back(ip[i]);
         for (int i = 0; i < pad; i++) f.push_back(8'($urandom_range(0, 255)));
      end
      if (cut > 0)
         while (f.size() > cut) void'(f.pop_back());
      foreach (f[i]) begin
         t.kind      = TRAFFIC_BYTE;
         t.data_byte = f[i];
         t.last      = (i == f.size() - 1);
         t.index     = '0;
         t.value     = '0;
         link_traffic.push_back(t);
      end
      n_bytes  += f.size();
      n_frames += 1;
   endtask

   // driver: frame bytes and register writes
   always @(posedge clock) begin : drive_link
      logic        req_next;
      logic        csr_next;
      traffic_type head;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
         traffic_done  <= 1'b0;
         byte_gap      = 0;
         quiet_cycles  = 0;
         req_calm      = 1'b0;
         req_calm_left = 50;
      end else begin
         req_next = req_bus.valid && !req_bus.ready;
         csr_next = csr_bus.valid && !csr_bus.ready;
         // count cycles with nothing in flight
         if (req_bus.valid || verdicts_due != 0) quiet_cycles = 0;
         else if (quiet_cycles < SETTLE) quiet_cycles++;
         if (!req_next) begin
            if (byte_gap > 0) begin
               byte_gap--;
            end else if (link_traffic.size() != 0) begin
               head = link_traffic[0];
               case (head.kind)
                  TRAFFIC_BYTE: begin
                     if (!csr_next) begin
                        req_bus.frame_byte <= head.data_byte;
                        req_bus.frame_end  <= head.last;
                        req_next = 1'b1;
                        void'(link_traffic.pop_front());
                        byte_gap = pick_gap(req_calm);
                        if (req_calm_left == 0) begin
                           req_calm      = ($urandom_range(0, 3) == 0);
                           req_calm_left = $urandom_range(20, 300);
                        end else begin
                           req_calm_left--;
                        end
                     end
                  end
                  TRAFFIC_CSR: begin
                     if (!csr_next && quiet_cycles >= SETTLE) begin
                        csr_bus.index <= head.index;
                        csr_bus.data  <= head.value;
                        csr_next = 1'b1;
                        void'(link_traffic.pop_front());
                     end
                  end
                  default: begin
                     if (quiet_cycles >= SETTLE) void'(link_traffic.pop_front());
                  end
               endcase
            end
         end
         req_bus.valid <= req_next;
         csr_bus.valid <= csr_next;
         traffic_done  <= (link_traffic.size() == 0) && !req_next && !csr_next;
      end
   end

   // monitor: predictor, verdict check and result-side stalls
   always @(posedge clock) begin : watch_verdicts
      verdict_rec_type want;
      logic [CSR_INDEX_W-1:0] idx;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         verdicts_due  <= 0;
         cfg_paint     = '0;
         cfg_bad_n     = '0;
         cfg_good_n    = '0;
         foreach (cfg_bad[i]) cfg_bad[i] = '0;
         foreach (cfg_good[i]) cfg_good[i] = '0;
         drops_so_far  = '0;
         clear_frame_state();
         stall_left    = 0;
         rsp_calm      = 1'b0;
         rsp_calm_left = 50;
      end else begin
         // result transfer
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: verdict with none expected, actual accept %0b reason %0d drops %0h",
                        $time, rsp_bus.accept, rsp_bus.drop_reason, rsp_bus.drop_count);
               mismatch_seen = 1'b1;
            end else begin
               want = expected_verdicts.pop_front();
               check_field("accept", want.accept, rsp_bus.accept);
               check_field("drop_reason", want.reason, rsp_bus.drop_reason);
               check_field("header_bytes", want.hdr_bytes, rsp_bus.header_bytes);
               check_field("kept_length", want.kept_len, rsp_bus.kept_length);
               check_field("dst_address", want.dst, rsp_bus.dst_address);
               check_field("color_out", want.color, rsp_bus.color_out);
               check_field("drop_count", want.drops, rsp_bus.drop_count);
            end
         end
         // register write transfer
         if (csr_bus.valid && csr_bus.ready) begin
            idx = csr_bus.index;
            if (idx == CSR_PAINT) cfg_paint = csr_bus.data[7:0];
            else if (idx == CSR_BAD_COUNT) cfg_bad_n = csr_bus.data[1:0];
            else if (idx == CSR_GOOD_COUNT) cfg_good_n = csr_bus.data[1:0];
            else if (idx >= CSR_BAD_0 && idx < CSR_BAD_0 + BAD_REG_SLOTS) begin
               if (idx - CSR_BAD_0 < BAD_SOURCE_SLOTS_DEF) cfg_bad[idx - CSR_BAD_0] = csr_bus.data;
            end else if (idx >= CSR_GOOD_0 && idx < CSR_GOOD_0 + GOOD_REG_SLOTS) begin
               if (idx - CSR_GOOD_0 < GOOD_DEST_SLOTS_DEF)
                  cfg_good[idx - CSR_GOOD_0] = csr_bus.data;
            end
         end
         // frame byte transfer
         if (req_bus.valid && req_bus.ready)
            track_frame_byte(req_bus.frame_byte, req_bus.frame_end);
         verdicts_due <= expected_verdicts.size();
         // result-side stalls, after transfers and at random
         if (rsp_calm_left == 0) begin
            rsp_calm      = ($urandom_range(0, 3) == 0);
            rsp_calm_left = $urandom_range(50, 600);
         end else begin
            rsp_calm_left--;
         end
         if (rsp_bus.valid && rsp_bus.ready) stall_left = pick_gap(rsp_calm);
         else if (stall_left == 0 && !rsp_calm && $urandom_range(0, 7) == 0)
            stall_left = pick_gap(1'b0);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      packet_kind_type kind;
      longint          start_bytes;
      int              frames;
      int              set_no;
      int              roll;
      int              cut;
      req_bus.valid      = 1'b0;
      req_bus.frame_byte = '0;
      req_bus.frame_end  = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      reset              = 1'b1;
      mismatch_seen      = 1'b0;
      cycle_count        = 0;
      cycle_limit        = 64'd1_000_000_000;
      n_bytes            = 0;
      n_frames           = 0;
      n_pauses           = 0;
      foreach (gen_bad[i]) gen_bad[i] = '0;
      foreach (gen_good[i]) gen_good[i] = '0;

      // reset settings: runts, every header fault, bad source with empty lists
      push_packet(PKT_GOOD, 5, 0, 1);
      push_packet(PKT_GOOD, 5, 0, LINK_BYTES - 1);
      push_packet(PKT_GOOD, 5, 0, LINK_BYTES + MIN_IP_HEADER - 1);
      push_packet(PKT_GOOD, 5, 0, 0);
      push_packet(PKT_GOOD, 15, 6, 0);
      push_packet(PKT_VERSION, 5, 4, 0);
      push_packet(PKT_HDR_LEN, 0, 4, 0);
      push_packet(PKT_TOTAL_LONG, 5, 3, 0);
      push_packet(PKT_TOTAL_SHORT, 6, 3, 0);
      push_packet(PKT_CSUM, 5, 2, 0);
      push_packet(PKT_BAD_SRC, 5, 2, 0);

      // extreme settings, a good count above the slots, an unmapped index
      push_pause();
      push_csr(CSR_PAINT, 32'hFFFF_FFFF);
      push_csr(CSR_BAD_COUNT, 32'd3);
      push_csr(CSR_BAD_0, 32'hFFFF_FFFF);
      push_csr(CSR_INDEX_W'(CSR_BAD_0 + 1), 32'h0000_0000);
      push_csr(CSR_INDEX_W'(CSR_BAD_0 + 2), $urandom());
      push_csr(CSR_GOOD_COUNT, 32'hFFFF_FFFF);
      push_csr(CSR_GOOD_0, $urandom());
      push_csr(CSR_INDEX_W'(CSR_GOOD_0 + 1), 32'hFFFF_FFFF);
      push_csr(CSR_INDEX_TOP, $urandom());
      for (int i = 0; i < 4; i++) push_packet(PKT_BAD_SRC, 0, i, 0);
      push_packet(PKT_GOOD, 5, 1, 0);

      // random phases, each under its own settings
      start_bytes = n_bytes;
      frames      = 0;
      set_no      = 0;
      while (n_bytes - start_bytes < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
         if (frames % FRAMES_PER_SET == 0) begin
            push_pause();
            push_csr(CSR_PAINT, (set_no == 0) ? 32'd0 : (set_no == 1) ? 32'd255 : $urandom());
            push_csr(CSR_BAD_COUNT, $urandom_range(0, 3));
            for (int i = 0; i < BAD_REG_SLOTS; i++)
               push_csr(CSR_INDEX_W'(CSR_BAD_0 + i), pick_addr());
            push_csr(CSR_GOOD_COUNT, $urandom_range(0, 3));
            for (int i = 0; i < GOOD_REG_SLOTS; i++)
               push_csr(CSR_INDEX_W'(CSR_GOOD_0 + i), pick_addr());
            if ($urandom_range(0, 2) == 0)
               push_csr(CSR_INDEX_W'($urandom_range(CSR_GOOD_0 + GOOD_REG_SLOTS, CSR_INDEX_TOP)),
                        $urandom());
            set_no++;
         end
         roll = $urandom_range(0, 99);
         cut  = 0;
         if (roll < 45) kind = PKT_GOOD;
         else if (roll < 60) kind = PKT_BAD_SRC;
         else if (roll < 65) kind = PKT_VERSION;
         else if (roll < 70) kind = PKT_HDR_LEN;
         else if (roll < 75) kind = PKT_TOTAL_LONG;
         else if (roll < 80) kind = PKT_TOTAL_SHORT;
         else if (roll < 88) kind = PKT_CSUM;
         else if (roll < 94) begin
            kind = PKT_GOOD;
            cut  = $urandom_range(1, LINK_BYTES + MIN_IP_HEADER - 1);
         end else kind = PKT_NOISE;
         if (kind == PKT_NOISE) push_packet(kind, 0, $urandom_range(1, 80), 0);
         else push_packet(kind, 0, $urandom_range(0, 40), cut);
         frames++;
         if ($urandom_range(0, 9) == 0) push_pause();
      end

      cycle_limit = 4 * (n_bytes * (MAX_GAP + 2) + n_frames * (MAX_GAP + 12)
                         + n_pauses * (SETTLE + 12) + 256) + 10000;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // drain everything, then let the pipeline settle
      @(negedge clock);
      while (!traffic_done) @(negedge clock);
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (SETTLE * 4) @(negedge clock);
      if (!mismatch_seen && expected_verdicts.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ipv4hc_pkg.sv
rtl/core/ipv4hc_if.sv
rtl/core/ipv4hc_verdict.sv
rtl/core/ipv4_input_header_check_unit.sv
tb/sv/tb.sv
